/* rtl/thc_pkg.sv */
`default_nettype none
package thc_pkg;

    typedef logic signed [63:0] word_t;
    typedef logic signed [31:0] trig_t;
    typedef logic signed [15:0] angle_t;

    localparam int ATAN_LEN = 24;
    localparam word_t HALF_PI_ANGLE = 64'sd1073741824;
    localparam word_t INV_GAIN_Q30 = 64'sd652032874;
    localparam int FRAC_BITS = 30;

    // atan(2^-i), 2^31 = pi
    function automatic word_t atan_step(input int idx);
        word_t r;
        unique case (idx)
            0:  r = 64'sh20000000;
            1:  r = 64'sh12E4051D;
            2:  r = 64'sh09FB385B;
            3:  r = 64'sh051111D4;
            4:  r = 64'sh028B0D43;
            5:  r = 64'sh0145D7E1;
            6:  r = 64'sh00A2F61E;
            7:  r = 64'sh00517C55;
            8:  r = 64'sh0028BE53;
            9:  r = 64'sh00145F2E;
            10: r = 64'sh000A2F98;
            11: r = 64'sh000517CC;
            12: r = 64'sh00028BE6;
            13: r = 64'sh000145F3;
            14: r = 64'sh0000A2F9;
            15: r = 64'sh0000517C;
            16: r = 64'sh000028BE;
            17: r = 64'sh0000145F;
            18: r = 64'sh00000A2F;
            19: r = 64'sh00000517;
            20: r = 64'sh0000028B;
            21: r = 64'sh00000145;
            22: r = 64'sh000000A2;
            23: r = 64'sh00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

    // round half up to 16-bit binary angle
    function automatic angle_t angle_round(input word_t z);
        word_t u;
        u = z + 64'sd32768;
        return u[31:16];
    endfunction

endpackage
`default_nettype wire

/* rtl/thc_vec.sv */
`default_nettype none
module thc_vec #(
    parameter int STAGES = 16,
    parameter int SW = 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  thc_pkg::word_t      in_x,
    input  thc_pkg::word_t      in_y,
    input  wire logic [SW-1:0]  in_side,
    output logic                out_valid,
    output thc_pkg::word_t      out_z,
    output logic [SW-1:0]       out_side
);
    import thc_pkg::*;

    word_t       x_reg [STAGES+1];
    word_t       y_reg [STAGES+1];
    word_t       z_reg [STAGES+1];
    logic        zero_reg [STAGES+1];
    logic        v_reg [STAGES+1];
    logic [SW-1:0] side_reg [STAGES+1];

    word_t x_next, y_next, z_next;

    // fold left half-plane into the right half
    always_comb
    begin
        x_next = in_x;
        y_next = in_y;
        z_next = '0;
        if (in_x < 0)
        begin
            if (in_y >= 0)
            begin
                x_next = in_y;
                y_next = -in_x;
                z_next = HALF_PI_ANGLE;
            end
            else
            begin
                x_next = -in_y;
                y_next = in_x;
                z_next = -HALF_PI_ANGLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= (in_x == 0) && (in_y == 0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        word_t xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + atan_step(i);
                end
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_z     = zero_reg[STAGES] ? '0 : z_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule
`default_nettype wire

/* rtl/thc_rot.sv */
`default_nettype none
module thc_rot #(
    parameter int STAGES = 16,
    parameter int SW = 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  thc_pkg::word_t      in_z,
    input  wire logic [SW-1:0]  in_side,
    output logic                out_valid,
    output thc_pkg::trig_t      out_cos,
    output thc_pkg::trig_t      out_sin,
    output logic [SW-1:0]       out_side
);
    import thc_pkg::*;

    word_t       x_reg [STAGES+1];
    word_t       y_reg [STAGES+1];
    word_t       z_reg [STAGES+1];
    logic        v_reg [STAGES+1];
    logic [SW-1:0] side_reg [STAGES+1];

    word_t x_next, y_next, z_next;

    // quarter-turn pre-rotation beyond +-pi/2
    always_comb
    begin
        x_next = INV_GAIN_Q30;
        y_next = '0;
        z_next = in_z;
        if (in_z > HALF_PI_ANGLE)
        begin
            x_next = '0;
            y_next = INV_GAIN_Q30;
            z_next = in_z - HALF_PI_ANGLE;
        end
        else if (in_z < -HALF_PI_ANGLE)
        begin
            x_next = '0;
            y_next = -INV_GAIN_Q30;
            z_next = in_z + HALF_PI_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        word_t xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + atan_step(i);
                end
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // results stay within about 1.0 in Q30
    assign out_valid = v_reg[STAGES];
    assign out_cos   = x_reg[STAGES][31:0];
    assign out_sin   = y_reg[STAGES][31:0];
    assign out_side  = side_reg[STAGES];

endmodule
`default_nettype wire

/* rtl/tilt_compensated_heading_core.sv */
// Throughput: one request per cycle while m_axis_tready does not stall; five pipelined CORDIC
// chains and five multiply/add stages each take a new request every cycle.
// Back-pressure freezes the whole pipeline at once; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
`default_nettype none
module tilt_compensated_heading_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z (16 bits each, from bit 0)
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pitch_angle, roll_angle, yaw_angle (16 bits each, from bit 0)
    output logic [47:0]      m_axis_tdata
);
    import thc_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int SW1 = 6 * SB;
    localparam int SW2 = 16 + 6 * SB;
    localparam int SW3 = 16 + 64 + 3 * SB;
    localparam int SW4 = 32 + 64 + 3 * SB;
    localparam int SW5 = 32;

    typedef logic signed [SB-1:0] samp_t;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // input register
    logic  r0_valid;
    samp_t ax_reg, ay_reg, az_reg, mx_reg, my_reg, mz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r0_valid <= 1'b0;
        else if (en)
            r0_valid <= s_axis_tvalid;
    end

    // low SB bits of each zero-extended 16-bit field
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= samp_t'({{SB{1'b0}}, s_axis_tdata[15:0]});
            ay_reg <= samp_t'({{SB{1'b0}}, s_axis_tdata[31:16]});
            az_reg <= samp_t'({{SB{1'b0}}, s_axis_tdata[47:32]});
            mx_reg <= samp_t'({{SB{1'b0}}, s_axis_tdata[63:48]});
            my_reg <= samp_t'({{SB{1'b0}}, s_axis_tdata[79:64]});
            mz_reg <= samp_t'({{SB{1'b0}}, s_axis_tdata[95:80]});
        end
    end

    // pitch = atan2(ay, -az)
    logic           v1_valid;
    word_t          pitch_z;
    logic [SW1-1:0] v1_side;
    word_t          v1_x, v1_y;

    assign v1_y = word_t'(ay_reg) <<< FRAC_BITS;
    assign v1_x = -(word_t'(az_reg) <<< FRAC_BITS);

    thc_vec #(.STAGES(CORDIC_STAGES), .SW(SW1)) u_vec_pitch (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(r0_valid), .in_x(v1_x), .in_y(v1_y),
        .in_side({ax_reg, ay_reg, az_reg, mx_reg, my_reg, mz_reg}),
        .out_valid(v1_valid), .out_z(pitch_z), .out_side(v1_side)
    );

    logic           c1_valid;
    trig_t          cp, sp;
    logic [SW2-1:0] c1_side;

    thc_rot #(.STAGES(CORDIC_STAGES), .SW(SW2)) u_rot_pitch (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v1_valid), .in_z(pitch_z),
        .in_side({angle_round(pitch_z), v1_side}),
        .out_valid(c1_valid), .out_cos(cp), .out_sin(sp), .out_side(c1_side)
    );

    angle_t c1_pitch;
    samp_t  c1_ax, c1_ay, c1_az, c1_mx, c1_my, c1_mz;
    assign {c1_pitch, c1_ax, c1_ay, c1_az, c1_mx, c1_my, c1_mz} = c1_side;

    // den = -ay*sp + az*cp over two stages
    logic   a_valid, b_valid;
    word_t  p1_reg, p2_reg, den_reg;
    angle_t a_pitch_reg, b_pitch_reg;
    trig_t  a_cp_reg, a_sp_reg, b_cp_reg, b_sp_reg;
    samp_t  a_ax_reg, a_mx_reg, a_my_reg, a_mz_reg;
    samp_t  b_ax_reg, b_mx_reg, b_my_reg, b_mz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid <= 1'b0;
            b_valid <= 1'b0;
        end
        else if (en)
        begin
            a_valid <= c1_valid;
            b_valid <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg      <= -(word_t'(c1_ay) * word_t'(sp));
            p2_reg      <= word_t'(c1_az) * word_t'(cp);
            a_pitch_reg <= c1_pitch;
            a_cp_reg    <= cp;
            a_sp_reg    <= sp;
            a_ax_reg    <= c1_ax;
            a_mx_reg    <= c1_mx;
            a_my_reg    <= c1_my;
            a_mz_reg    <= c1_mz;

            den_reg     <= p1_reg + p2_reg;
            b_pitch_reg <= a_pitch_reg;
            b_cp_reg    <= a_cp_reg;
            b_sp_reg    <= a_sp_reg;
            b_ax_reg    <= a_ax_reg;
            b_mx_reg    <= a_mx_reg;
            b_my_reg    <= a_my_reg;
            b_mz_reg    <= a_mz_reg;
        end
    end

    // roll = atan2(ax, den)
    logic           v2_valid;
    word_t          roll_z;
    logic [SW3-1:0] v2_side;

    thc_vec #(.STAGES(CORDIC_STAGES), .SW(SW3)) u_vec_roll (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(b_valid), .in_x(den_reg),
        .in_y(word_t'(b_ax_reg) <<< FRAC_BITS),
        .in_side({b_pitch_reg, b_cp_reg, b_sp_reg, b_mx_reg, b_my_reg, b_mz_reg}),
        .out_valid(v2_valid), .out_z(roll_z), .out_side(v2_side)
    );

    logic           c2_valid;
    trig_t          cr, sr;
    logic [SW4-1:0] c2_side;

    thc_rot #(.STAGES(CORDIC_STAGES), .SW(SW4)) u_rot_roll (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v2_valid), .in_z(roll_z),
        .in_side({angle_round(roll_z), v2_side}),
        .out_valid(c2_valid), .out_cos(cr), .out_sin(sr), .out_side(c2_side)
    );

    angle_t c2_roll, c2_pitch;
    trig_t  c2_cp, c2_sp;
    samp_t  c2_mx, c2_my, c2_mz;
    assign {c2_roll, c2_pitch, c2_cp, c2_sp, c2_mx, c2_my, c2_mz} = c2_side;

    // magnetic field rotated into the level plane, three stages
    logic   c_valid, d_valid, e_valid;
    word_t  t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    word_t  d_t1_reg, d_t4_reg, d_t5_reg, u1_reg, u2_reg;
    word_t  bfx_reg, bfy_reg;
    samp_t  c_my_reg, c_mz_reg;
    angle_t c_pitch_reg, c_roll_reg, d_pitch_reg, d_roll_reg, e_pitch_reg, e_roll_reg;
    trig_t  ss_q30, cs_q30;

    assign ss_q30 = trig_t'(t2_reg >>> FRAC_BITS);
    assign cs_q30 = trig_t'(t3_reg >>> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid <= 1'b0;
            d_valid <= 1'b0;
            e_valid <= 1'b0;
        end
        else if (en)
        begin
            c_valid <= c2_valid;
            d_valid <= c_valid;
            e_valid <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg      <= word_t'(c2_mx) * word_t'(cr);
            t2_reg      <= word_t'(c2_sp) * word_t'(sr);
            t3_reg      <= word_t'(c2_cp) * word_t'(sr);
            t4_reg      <= word_t'(c2_my) * word_t'(c2_cp);
            t5_reg      <= word_t'(c2_mz) * word_t'(c2_sp);
            c_my_reg    <= c2_my;
            c_mz_reg    <= c2_mz;
            c_pitch_reg <= c2_pitch;
            c_roll_reg  <= c2_roll;

            u1_reg      <= word_t'(c_my_reg) * word_t'(ss_q30);
            u2_reg      <= word_t'(c_mz_reg) * word_t'(cs_q30);
            d_t1_reg    <= t1_reg;
            d_t4_reg    <= t4_reg;
            d_t5_reg    <= t5_reg;
            d_pitch_reg <= c_pitch_reg;
            d_roll_reg  <= c_roll_reg;

            bfx_reg     <= d_t1_reg + u1_reg - u2_reg;
            bfy_reg     <= d_t4_reg + d_t5_reg;
            e_pitch_reg <= d_pitch_reg;
            e_roll_reg  <= d_roll_reg;
        end
    end

    // yaw = atan2(bfx, -bfy)
    logic           v3_valid;
    word_t          yaw_z;
    logic [SW5-1:0] v3_side;

    thc_vec #(.STAGES(CORDIC_STAGES), .SW(SW5)) u_vec_yaw (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(e_valid), .in_x(-bfy_reg), .in_y(bfx_reg),
        .in_side({e_roll_reg, e_pitch_reg}),
        .out_valid(v3_valid), .out_z(yaw_z), .out_side(v3_side)
    );

    // output register
    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v3_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {angle_round(yaw_z), v3_side};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> r0_valid)
        else $error("accepted request did not enter the pipeline");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(a_valid) && $stable(c_valid) && $stable(r0_valid))
        else $error("pipeline moved during a stall");

    a_yaw_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && v3_valid |=> m_axis_tvalid)
        else $error("finished result lost before the output register");

endmodule
`default_nettype wire

/* test/tb_tilt_compensated_heading_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_tilt_compensated_heading_core;
    import thc_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY = 5 * CORDIC_STAGES + 12;
    localparam longint Q30 = 64'sd1 << 30;

    typedef struct packed {
        angle_t yaw;
        angle_t roll;
        angle_t pitch;
    } heading_t;

    typedef struct {
        logic signed [15:0] ax, ay, az, mx, my, mz;
    } sensor_t;

    // atan(2^-i), 2^31 = pi
    localparam longint ATAN_TAB [0:23] = '{
        64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
        64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

    function automatic longint vec_angle(longint y, longint x);
        longint z, xs, ys, t;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 64'sd1073741824;
            end
            else
            begin
                x = -y; y = t; z = -64'sd1073741824;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0)
            begin
                x = x - ys; y = y + xs; z -= ATAN_TAB[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z += ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic void rot_trig(input longint z, output longint c, output longint s);
        longint x, y, xs, ys;
        x = 64'sd652032874;
        y = 0;
        if (z > 64'sd1073741824)
        begin
            x = 0; y = 64'sd652032874; z -= 64'sd1073741824;
        end
        else if (z < -64'sd1073741824)
        begin
            x = 0; y = -64'sd652032874; z += 64'sd1073741824;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z -= ATAN_TAB[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z += ATAN_TAB[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic angle_t to_bam16(longint z);
        logic [63:0] u;
        u = z + 64'sd32768;
        return u[31:16];
    endfunction

    function automatic heading_t calc_heading(sensor_t v);
        longint ax, ay, az, mx, my, mz;
        longint pitch, roll, yaw, cp, sp, cr, sr, den, bfx, bfy;
        heading_t h;
        ax = v.ax; ay = v.ay; az = v.az;
        mx = v.mx; my = v.my; mz = v.mz;
        pitch = vec_angle(ay * Q30, -az * Q30);
        rot_trig(pitch, cp, sp);
        den = -ay * sp + az * cp;
        roll = vec_angle(ax * Q30, den);
        rot_trig(roll, cr, sr);
        bfx = mx * cr + my * ((sp * sr) >>> 30) - mz * ((cp * sr) >>> 30);
        bfy = my * cp + mz * sp;
        yaw = vec_angle(bfx, -bfy);
        h.pitch = to_bam16(pitch);
        h.roll = to_bam16(roll);
        h.yaw = to_bam16(yaw);
        return h;
    endfunction

    class heading_scoreboard;
        heading_t pending[$];
        int errors;
        int checked;

        function void note_request(sensor_t v);
            pending.push_back(calc_heading(v));
        endfunction

        function void check_result(logic [47:0] d);
            heading_t got, exp_h;
            got = d;
            if (pending.size() == 0)
            begin
                $error("result with nothing pending: %h", d);
                errors++;
                return;
            end
            exp_h = pending.pop_front();
            checked++;
            if (got.pitch !== exp_h.pitch)
            begin
                $error("pitch_angle expected %0d actual %0d", exp_h.pitch, got.pitch);
                errors++;
            end
            if (got.roll !== exp_h.roll)
            begin
                $error("roll_angle expected %0d actual %0d", exp_h.roll, got.roll);
                errors++;
            end
            if (got.yaw !== exp_h.yaw)
            begin
                $error("yaw_angle expected %0d actual %0d", exp_h.yaw, got.yaw);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int sent = 0;
    sensor_t directed[$];

    heading_scoreboard sb = new();

    always #1 clk = ~clk;

    tilt_compensated_heading_core #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic logic [95:0] pack_sensor(sensor_t v);
        return {v.mz, v.my, v.mx, v.az, v.ay, v.ax};
    endfunction

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'($urandom_range(0, 15) - 8);
            4: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sensor_t rand_sensor();
        sensor_t v;
        v.ax = rand_comp(); v.ay = rand_comp(); v.az = rand_comp();
        v.mx = rand_comp(); v.my = rand_comp(); v.mz = rand_comp();
        // plausible gravity vectors most of the time
        if ($urandom_range(0, 3) != 0)
        begin
            v.ax = 16'($urandom_range(0, 32767) - 16384);
            v.ay = 16'($urandom_range(0, 32767) - 16384);
            v.az = 16'($urandom_range(0, 32767) - 16384);
        end
        return v;
    endfunction

    // valid stays high after a request unless the next one idles first
    task automatic send_request(sensor_t v);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_sensor(v);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(v);
        sent++;
    endtask

    task automatic add_dir(int ax, int ay, int az, int mx, int my, int mz);
        sensor_t v;
        v.ax = 16'(ax); v.ay = 16'(ay); v.az = 16'(az);
        v.mx = 16'(mx); v.my = 16'(my); v.mz = 16'(mz);
        directed.push_back(v);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // receiver
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_dir(0, 0, 0, 0, 0, 0);
        add_dir(0, 0, -16384, 1000, 0, 0);
        add_dir(0, 0, 16384, 0, 1000, 0);
        add_dir(0, 0, -1, 0, 0, 0);
        add_dir(500, 0, 0, 300, 200, 100);
        add_dir(-500, 0, 0, -300, 200, -100);
        add_dir(0, 0, 1, 0, 0, 0);
        add_dir(0, -100, 0, 0, -1, 0);
        add_dir(32767, 32767, 32767, 32767, 32767, 32767);
        add_dir(-32768, -32768, -32768, -32768, -32768, -32768);
        add_dir(32767, -32768, 32767, -32768, 32767, -32768);
        add_dir(-32768, 32767, -32768, 32767, -32768, 32767);
        add_dir(0, 0, 0, 0, 0, 5);
        add_dir(0, 0, 0, -5, 0, 0);
        add_dir(0, 0, -16384, -1000, 0, 0);
        add_dir(0, 0, -16384, -1000, -1, 0);
        add_dir(1, 1, 1, 1, 1, 1);
        add_dir(-1, -1, -1, -1, -1, -1);
        add_dir(16384, 0, 16384, 0, 0, 0);
        add_dir(0, 16384, 0, 0, 0, 0);
        foreach (directed[i])
            send_request(directed[i]);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 75 : 22) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 75 : 22) : 0;
            if (ph == 0)
            begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            repeat (210)
                send_request(rand_sensor());
            drain();
        end
        recv_stall_pct = 0;
        repeat (LATENCY + 20) @(posedge clk);

        $display("Sent %0d sensor vectors, checked %0d headings", sent, sb.checked);
        $display("Phases: directed corners, back-to-back, sender gaps, sink stalls, mixed");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
